@@ rtl/chtab_pkg.sv @@
// ----------------------------------------------------------------------------
// Chained hash table package
// Field widths, command codes and status codes shared by the table core
// and its bucket hash unit.
// ----------------------------------------------------------------------------
package chtab_pkg;

   // Field widths of the request and response beats.
   localparam int CMD_W       = 2;
   localparam int KEY_W       = 16;
   localparam int NAME_W      = 40;
   localparam int VALUE_W     = 32;
   localparam int STATUS_W    = 2;
   localparam int SLOT_OUT_W  = 5;
   localparam int COUNT_OUT_W = 6;

   typedef logic [CMD_W-1:0]    cmd_type;
   typedef logic [STATUS_W-1:0] status_type;

   // Command codes.
   localparam cmd_type CMD_INSERT = 2'd0;
   localparam cmd_type CMD_DELETE = 2'd1;
   localparam cmd_type CMD_SEARCH = 2'd2;

   // Status codes.
   localparam status_type STS_OK        = 2'd0;
   localparam status_type STS_NOT_FOUND = 2'd1;
   localparam status_type STS_DUPLICATE = 2'd2;
   localparam status_type STS_FULL      = 2'd3;

endpackage

@@ rtl/chtab_hash.sv @@
// ----------------------------------------------------------------------------
// Chained hash table bucket hash
// Computes key modulo BUCKETS by reciprocal multiplication on one shared
// multiplier: quotient, quotient times BUCKETS, then one subtract.
// ----------------------------------------------------------------------------
module chtab_hash #(
   parameter int BUCKETS = 31
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [chtab_pkg::KEY_W-1:0]           key,
   output logic                                  done,
   output logic [((BUCKETS > 1) ? $clog2(BUCKETS) : 1)-1:0] bucket
);

   localparam int KW    = chtab_pkg::KEY_W;
   localparam int CB    = $clog2(BUCKETS);
   localparam int BKT_W = (BUCKETS > 1) ? CB : 1;
   localparam int SHIFT = KW + CB;
   localparam int MW    = KW + 1;
   localparam int PW    = KW + MW;
   // Rounded-up reciprocal: the quotient is exact for every key of KW bits.
   localparam logic [MW-1:0] RECIP   = MW'(((1 << SHIFT) + BUCKETS - 1) / BUCKETS);
   localparam logic [MW-1:0] MODULUS = MW'(BUCKETS);

   // Step codes.
   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_QUOT = 2'd1;
   localparam logic [1:0] PH_PROD = 2'd2;
   localparam logic [1:0] PH_SUB  = 2'd3;

   logic [1:0]       phase_ff, phase_in;
   logic [KW-1:0]    key_ff, key_in;
   logic [PW-1:0]    prod_ff, prod_in;
   logic [BKT_W-1:0] rem_ff, rem_in;
   logic [KW-1:0]    quot;
   logic [KW-1:0]    mul_a;
   logic [MW-1:0]    mul_b;
   logic [PW-1:0]    mul_p;

   assign quot = KW'(prod_ff >> SHIFT);

   // Shared multiplier: key times reciprocal, then quotient times modulus.
   always_comb begin
      if (phase_ff == PH_QUOT) begin
         mul_a = key_ff;
         mul_b = RECIP;
      end else begin
         mul_a = quot;
         mul_b = MODULUS;
      end
      mul_p = PW'(mul_a) * PW'(mul_b);
   end

   // Step sequencing.
   always_comb begin
      phase_in = phase_ff;
      key_in   = key_ff;
      prod_in  = prod_ff;
      rem_in   = rem_ff;
      case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               key_in   = key;
               phase_in = PH_QUOT;
            end
         end
         PH_QUOT: begin
            prod_in  = mul_p;
            phase_in = PH_PROD;
         end
         PH_PROD: begin
            prod_in  = mul_p;
            phase_in = PH_SUB;
         end
         PH_SUB: begin
            rem_in   = BKT_W'(key_ff - prod_ff[KW-1:0]);
            phase_in = PH_IDLE;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
      key_ff  <= key_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
   end

   // The remainder is valid from the cycle after done and holds until the
   // next start.
   assign done   = (phase_ff == PH_SUB);
   assign bucket = rem_ff;

endmodule

@@ rtl/chained_hash_table_core.sv @@
// ----------------------------------------------------------------------------
// Chained hash table core
// Keyed record store: each bucket heads a linked chain of slots in a fixed
// pool, free slots form a stack threaded through the link field. A request
// inserts, deletes or searches by key and yields one response beat.
//
//   Channel   Direction  Beat contents
//   req_*     in         command, key, rec_name, rec_value
//   rsp_*     out        status, slot, found_name, found_value, entry_count
//
// After reset a clearing pass empties the bucket heads and threads the free
// stack; req_ready stays low meanwhile. A request steps through the idle
// state, the modulo unit, a head read, a walk start, the link compares (up
// to ENTRIES), INS0 to INS2 for a new insert or DEL1 and DEL2 for a delete,
// and a response state. A full insert or the unused command goes from idle
// straight to the response. A held response beat stalls the core.
// ----------------------------------------------------------------------------
module chained_hash_table_core #(
   parameter int BUCKETS = 31,
   parameter int ENTRIES = 32
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic [chtab_pkg::CMD_W-1:0]               req_command,
   input  logic [chtab_pkg::KEY_W-1:0]               req_key,
   input  logic [chtab_pkg::NAME_W-1:0]              req_rec_name,
   input  logic signed [chtab_pkg::VALUE_W-1:0]      req_rec_value,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic [chtab_pkg::STATUS_W-1:0]            rsp_status,
   output logic [chtab_pkg::SLOT_OUT_W-1:0]          rsp_slot,
   output logic [chtab_pkg::NAME_W-1:0]              rsp_found_name,
   output logic signed [chtab_pkg::VALUE_W-1:0]      rsp_found_value,
   output logic [chtab_pkg::COUNT_OUT_W-1:0]         rsp_entry_count
);

   localparam int SLOT_W = $clog2(ENTRIES + 1);
   localparam int IDX_W  = $clog2(ENTRIES);
   localparam int CB     = $clog2(BUCKETS);
   localparam int BKT_W  = (BUCKETS > 1) ? CB : 1;
   localparam int CLR_N  = (BUCKETS > ENTRIES) ? BUCKETS : ENTRIES;
   localparam int CLR_W  = $clog2(CLR_N);
   localparam logic [SLOT_W-1:0] END_MARK = SLOT_W'(ENTRIES);

   // Sequencer state codes.
   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_HASH  = 4'd2;
   localparam logic [3:0] ST_HEAD  = 4'd3;
   localparam logic [3:0] ST_START = 4'd4;
   localparam logic [3:0] ST_WALK  = 4'd5;
   localparam logic [3:0] ST_INS0  = 4'd6;
   localparam logic [3:0] ST_INS1  = 4'd7;
   localparam logic [3:0] ST_INS2  = 4'd8;
   localparam logic [3:0] ST_DEL1  = 4'd9;
   localparam logic [3:0] ST_DEL2  = 4'd10;
   localparam logic [3:0] ST_RESP  = 4'd11;

   // Bucket heads and the entry pool.
   logic [SLOT_W-1:0]                    head_mem  [BUCKETS];
   logic [chtab_pkg::KEY_W-1:0]          key_mem   [ENTRIES];
   logic [chtab_pkg::NAME_W-1:0]         name_mem  [ENTRIES];
   logic [chtab_pkg::VALUE_W-1:0]        value_mem [ENTRIES];
   logic [SLOT_W-1:0]                    link_mem  [ENTRIES];

   logic [3:0]                           state_ff, state_in;
   logic [CLR_W-1:0]                     clr_ff, clr_in;
   logic [chtab_pkg::CMD_W-1:0]          cmd_ff;
   logic [chtab_pkg::KEY_W-1:0]          key_ff;
   logic [chtab_pkg::NAME_W-1:0]         name_ff;
   logic [chtab_pkg::VALUE_W-1:0]        value_ff;
   logic [SLOT_W-1:0]                    cur_ff, cur_in;
   logic [SLOT_W-1:0]                    prev_ff, prev_in;
   logic [SLOT_W-1:0]                    steps_ff, steps_in;
   logic [SLOT_W-1:0]                    dlink_ff, dlink_in;
   logic [SLOT_W-1:0]                    free_top_ff, free_top_in;
   logic [SLOT_W-1:0]                    occ_ff, occ_in;
   logic [chtab_pkg::STATUS_W-1:0]       res_status_ff, res_status_in;
   logic [SLOT_W-1:0]                    res_slot_ff, res_slot_in;
   logic                                 res_hit_ff, res_hit_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic                                 rsp_load;
   logic [chtab_pkg::STATUS_W-1:0]       rsp_status_ff;
   logic [chtab_pkg::SLOT_OUT_W-1:0]     rsp_slot_ff;
   logic [chtab_pkg::NAME_W-1:0]         rsp_name_ff;
   logic [chtab_pkg::VALUE_W-1:0]        rsp_value_ff;
   logic [chtab_pkg::COUNT_OUT_W-1:0]    rsp_count_ff;

   logic                                 req_accept;
   logic                                 hash_start;
   logic                                 hash_done;
   logic [BKT_W-1:0]                     bucket;

   // Pool read port, registered data.
   logic                                 rd_en;
   logic [IDX_W-1:0]                     rd_addr;
   logic [chtab_pkg::KEY_W-1:0]          key_q;
   logic [chtab_pkg::NAME_W-1:0]         name_q;
   logic [chtab_pkg::VALUE_W-1:0]        value_q;
   logic [SLOT_W-1:0]                    link_q;
   logic                                 head_re;
   logic [SLOT_W-1:0]                    head_q;

   // Write ports.
   logic                                 ent_we;
   logic                                 link_we;
   logic [IDX_W-1:0]                     link_wa;
   logic [SLOT_W-1:0]                    link_wd;
   logic                                 head_we;
   logic [BKT_W-1:0]                     head_wa;
   logic [SLOT_W-1:0]                    head_wd;

   logic                                 walk_hit;
   logic                                 walk_miss;
   logic [SLOT_W-1:0]                    steps_next;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign steps_next = steps_ff + SLOT_W'(1);

   // Key modulo BUCKETS.
   chtab_hash #(
      .BUCKETS (BUCKETS)
   ) u_hash (
      .clock  (clock),
      .reset  (reset),
      .start  (hash_start),
      .key    (req_key),
      .done   (hash_done),
      .bucket (bucket)
   );

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      steps_in      = steps_ff;
      dlink_in      = dlink_ff;
      free_top_in   = free_top_ff;
      occ_in        = occ_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_hit_in    = res_hit_ff;
      hash_start    = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = free_top_ff[IDX_W-1:0];
      head_re       = 1'b0;
      ent_we        = 1'b0;
      link_we       = 1'b0;
      link_wa       = prev_ff[IDX_W-1:0];
      link_wd       = res_slot_ff;
      head_we       = 1'b0;
      head_wa       = bucket;
      head_wd       = res_slot_ff;
      walk_hit      = 1'b0;
      walk_miss     = 1'b0;
      rsp_load      = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            // Empty every bucket and thread slot i to slot i+1.
            if ({1'b0, clr_ff} < (CLR_W + 1)'(BUCKETS)) begin
               head_we = 1'b1;
               head_wa = clr_ff[BKT_W-1:0];
               head_wd = END_MARK;
            end
            if ({1'b0, clr_ff} < (CLR_W + 1)'(ENTRIES)) begin
               link_we = 1'b1;
               link_wa = clr_ff[IDX_W-1:0];
               link_wd = SLOT_W'(clr_ff) + SLOT_W'(1);
            end
            if (clr_ff == CLR_W'(CLR_N - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + CLR_W'(1);
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               res_slot_in = '0;
               res_hit_in  = 1'b0;
               if ((req_command == chtab_pkg::CMD_INSERT) &&
                   ((occ_ff >= END_MARK) || (free_top_ff >= END_MARK))) begin
                  res_status_in = chtab_pkg::STS_FULL;
                  state_in      = ST_RESP;
               end else if ((req_command == chtab_pkg::CMD_INSERT) ||
                            (req_command == chtab_pkg::CMD_DELETE) ||
                            (req_command == chtab_pkg::CMD_SEARCH)) begin
                  state_in = ST_HASH;
               end else begin
                  res_status_in = chtab_pkg::STS_NOT_FOUND;
                  state_in      = ST_RESP;
               end
            end
         end
         ST_HASH: begin
            // The hash unit took the key at acceptance; wait for its remainder.
            if (hash_done) begin
               state_in = ST_HEAD;
            end
         end
         ST_HEAD: begin
            head_re  = 1'b1;
            state_in = ST_START;
         end
         ST_START: begin
            cur_in   = head_q;
            prev_in  = END_MARK;
            steps_in = '0;
            if (head_q < END_MARK) begin
               rd_en    = 1'b1;
               rd_addr  = head_q[IDX_W-1:0];
               state_in = ST_WALK;
            end else begin
               walk_miss = 1'b1;
            end
         end
         ST_WALK: begin
            // One link per cycle: compare the slot just read, fetch the next.
            if (key_q == key_ff) begin
               walk_hit = 1'b1;
            end else begin
               prev_in  = cur_ff;
               steps_in = steps_next;
               if ((link_q < END_MARK) && (steps_next < END_MARK)) begin
                  cur_in  = link_q;
                  rd_en   = 1'b1;
                  rd_addr = link_q[IDX_W-1:0];
               end else begin
                  walk_miss = 1'b1;
               end
            end
         end
         ST_INS0: begin
            rd_en    = 1'b1;
            rd_addr  = free_top_ff[IDX_W-1:0];
            state_in = ST_INS1;
         end
         ST_INS1: begin
            // Pop the free stack and write the new entry as a chain tail.
            free_top_in = link_q;
            res_slot_in = free_top_ff;
            ent_we      = 1'b1;
            link_we     = 1'b1;
            link_wa     = free_top_ff[IDX_W-1:0];
            link_wd     = END_MARK;
            state_in    = ST_INS2;
         end
         ST_INS2: begin
            if (prev_ff < END_MARK) begin
               link_we = 1'b1;
            end else begin
               head_we = 1'b1;
            end
            occ_in        = occ_ff + SLOT_W'(1);
            res_status_in = chtab_pkg::STS_OK;
            state_in      = ST_RESP;
         end
         ST_DEL1: begin
            // Bridge the chain around the deleted slot.
            link_wd = dlink_ff;
            head_wd = dlink_ff;
            if (prev_ff < END_MARK) begin
               link_we = 1'b1;
            end else begin
               head_we = 1'b1;
            end
            state_in = ST_DEL2;
         end
         ST_DEL2: begin
            // Push the freed slot onto the free stack.
            link_we     = 1'b1;
            link_wa     = cur_ff[IDX_W-1:0];
            link_wd     = free_top_ff;
            free_top_in = cur_ff;
            if (occ_ff != '0) begin
               occ_in = occ_ff - SLOT_W'(1);
            end
            res_status_in = chtab_pkg::STS_OK;
            res_slot_in   = cur_ff;
            state_in      = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // End of a chain without a match.
      if (walk_miss) begin
         if (cmd_ff == chtab_pkg::CMD_INSERT) begin
            state_in = ST_INS0;
         end else begin
            res_status_in = chtab_pkg::STS_NOT_FOUND;
            res_slot_in   = '0;
            state_in      = ST_RESP;
         end
      end

      // Key found at the current slot.
      if (walk_hit) begin
         res_slot_in = cur_ff;
         case (cmd_ff)
            chtab_pkg::CMD_INSERT: begin
               res_status_in = chtab_pkg::STS_DUPLICATE;
               state_in      = ST_RESP;
            end
            chtab_pkg::CMD_DELETE: begin
               dlink_in = link_q;
               state_in = ST_DEL1;
            end
            default: begin
               res_status_in = chtab_pkg::STS_OK;
               res_hit_in    = 1'b1;
               state_in      = ST_RESP;
            end
         endcase
      end

      hash_start = req_accept && (state_in == ST_HASH);
   end

   // Response register: a finished beat waits here for rsp_ready.
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         free_top_ff  <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         free_top_ff  <= free_top_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers of the current request.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff   <= req_command;
         key_ff   <= req_key;
         name_ff  <= req_rec_name;
         value_ff <= req_rec_value;
      end
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      steps_ff      <= steps_in;
      dlink_ff      <= dlink_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_hit_ff    <= res_hit_in;
   end

   // Response payload.
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_slot_ff   <= chtab_pkg::SLOT_OUT_W'(res_slot_ff);
         rsp_name_ff   <= res_hit_ff ? name_q : '0;
         rsp_value_ff  <= res_hit_ff ? value_q : '0;
         rsp_count_ff  <= chtab_pkg::COUNT_OUT_W'(occ_ff);
      end
   end

   // Bucket head memory.
   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[head_wa] <= head_wd;
      end
      if (head_re) begin
         head_q <= head_mem[bucket];
      end
   end

   // Entry pool memories.
   always_ff @(posedge clock) begin
      if (ent_we) begin
         key_mem[free_top_ff[IDX_W-1:0]]   <= key_ff;
         name_mem[free_top_ff[IDX_W-1:0]]  <= name_ff;
         value_mem[free_top_ff[IDX_W-1:0]] <= value_ff;
      end
      if (link_we) begin
         link_mem[link_wa] <= link_wd;
      end
      if (rd_en) begin
         key_q   <= key_mem[rd_addr];
         name_q  <= name_mem[rd_addr];
         value_q <= value_mem[rd_addr];
         link_q  <= link_mem[rd_addr];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_slot        = rsp_slot_ff;
   assign rsp_found_name  = rsp_name_ff;
   assign rsp_found_value = rsp_value_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

@@ tb/chained_hash_table_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Chained hash table core testbench
// Feeds insert, delete and search requests through the request channel and
// checks every response beat against a behavioral copy of the bucket chains
// and the free-slot stack. A directed opening covers field extremes, chain
// head, middle and tail cases and the unused command. Random phases follow
// with changing command mixes and key pools that crowd a few buckets, so
// the table fills up and chains grow long. Both channels idle in random
// bursts, except in calm stretches and in the final phase.
// ----------------------------------------------------------------------------
module chained_hash_table_core_tb;

   localparam int BUCKETS = 31;
   localparam int ENTRIES = 32;
   localparam logic [5:0] NO_SLOT = 6'(ENTRIES);
   localparam chtab_pkg::cmd_type CMD_UNUSED = 2'd3;
   localparam int QUIET_LIMIT = 2000;
   localparam int PHASES = 9;
   localparam int PHASE_LEN = 150;
   localparam int POOL_SIZE = 40;
   localparam int SHOWN_MISMATCHES = 40;

   // One request beat, plus the flags that steer the sender.
   typedef struct {
      chtab_pkg::cmd_type                          command;
      logic [chtab_pkg::KEY_W-1:0]                 key;
      logic [chtab_pkg::NAME_W-1:0]                name;
      logic signed [chtab_pkg::VALUE_W-1:0]        value;
      bit                                          drain_first;
      bit                                          calm;
   } table_req_type;

   // One response beat.
   typedef struct {
      chtab_pkg::status_type                       status;
      logic [chtab_pkg::SLOT_OUT_W-1:0]            slot;
      logic [chtab_pkg::NAME_W-1:0]                name;
      logic signed [chtab_pkg::VALUE_W-1:0]        value;
      logic [chtab_pkg::COUNT_OUT_W-1:0]           count;
   } table_rsp_type;

   logic                                    clock = 1'b0;
   logic                                    reset = 1'b1;
   logic                                    req_valid = 1'b0;
   logic                                    req_ready;
   logic [chtab_pkg::CMD_W-1:0]             req_command = '0;
   logic [chtab_pkg::KEY_W-1:0]             req_key = '0;
   logic [chtab_pkg::NAME_W-1:0]            req_rec_name = '0;
   logic signed [chtab_pkg::VALUE_W-1:0]    req_rec_value = '0;
   logic                                    rsp_valid;
   logic                                    rsp_ready = 1'b0;
   logic [chtab_pkg::STATUS_W-1:0]          rsp_status;
   logic [chtab_pkg::SLOT_OUT_W-1:0]        rsp_slot;
   logic [chtab_pkg::NAME_W-1:0]            rsp_found_name;
   logic signed [chtab_pkg::VALUE_W-1:0]    rsp_found_value;
   logic [chtab_pkg::COUNT_OUT_W-1:0]       rsp_entry_count;

   chained_hash_table_core #(
      .BUCKETS (BUCKETS),
      .ENTRIES (ENTRIES)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_key         (req_key),
      .req_rec_name    (req_rec_name),
      .req_rec_value   (req_rec_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_slot        (rsp_slot),
      .rsp_found_name  (rsp_found_name),
      .rsp_found_value (rsp_found_value),
      .rsp_entry_count (rsp_entry_count)
   );

   // Shadow copy of the table: chain heads, slot pool and free stack.
   logic [5:0]                              head_of [BUCKETS];
   logic [chtab_pkg::KEY_W-1:0]             key_at [ENTRIES];
   logic [chtab_pkg::NAME_W-1:0]            name_at [ENTRIES];
   logic signed [chtab_pkg::VALUE_W-1:0]    value_at [ENTRIES];
   logic [5:0]                              next_of [ENTRIES];
   logic [5:0]                              free_head;
   logic [5:0]                              live_count;

   table_req_type                           pending_lookups [$];
   table_rsp_type                           predicted_replies [$];
   logic [chtab_pkg::KEY_W-1:0]             key_pool [POOL_SIZE];

   logic                          req_beat_done = 1'b0;
   logic                          no_idling = 1'b0;
   int                            send_gap = 0;
   int                            stall_left = 0;
   int                            quiet_cycles = 0;
   int                            mismatches = 0;
   int                            requests_taken = 0;
   int                            replies_seen = 0;
   int                            longest_walk = 0;
   int                            peak_count = 0;
   int                            status_tally [4] = '{default: 0};

   // Free-running clock.
   initial begin : clock_gen
      forever #2 clock = ~clock;
   end

   // Walk one bucket chain. The hit is the slot holding the key, the tail is
   // the slot before the hit, or the last slot when the key is missing.
   function automatic void find_in_chain(input int bucket,
                                         input logic [chtab_pkg::KEY_W-1:0] k,
                                         output logic [5:0] hit,
                                         output logic [5:0] tail);
      logic [5:0] cur;
      int         steps;
      cur = head_of[bucket];
      hit = NO_SLOT;
      tail = NO_SLOT;
      steps = 0;
      while (cur < NO_SLOT && steps < ENTRIES) begin
         if (key_at[cur] == k) begin
            hit = cur;
            break;
         end
         tail = cur;
         cur = next_of[cur];
         steps++;
      end
      if (steps > longest_walk) longest_walk = steps;
   endfunction

   // Apply one request to the shadow table and return the response it earns.
   function automatic table_rsp_type table_step(input table_req_type r);
      table_rsp_type e;
      logic [5:0] hit;
      logic [5:0] tail;
      logic [5:0] fresh;
      int         bucket;
      e.status = chtab_pkg::STS_NOT_FOUND;
      e.slot = '0;
      e.name = '0;
      e.value = '0;
      bucket = int'(r.key) % BUCKETS;
      case (r.command)
         chtab_pkg::CMD_INSERT: begin
            // A full pool wins over a duplicate key.
            if (live_count >= ENTRIES || free_head >= NO_SLOT) begin
               e.status = chtab_pkg::STS_FULL;
            end else begin
               find_in_chain(bucket, r.key, hit, tail);
               if (hit < NO_SLOT) begin
                  e.status = chtab_pkg::STS_DUPLICATE;
                  e.slot = hit[chtab_pkg::SLOT_OUT_W-1:0];
               end else begin
                  fresh = free_head;
                  free_head = next_of[fresh];
                  key_at[fresh] = r.key;
                  name_at[fresh] = r.name;
                  value_at[fresh] = r.value;
                  next_of[fresh] = NO_SLOT;
                  if (tail < NO_SLOT) next_of[tail] = fresh;
                  else head_of[bucket] = fresh;
                  live_count++;
                  e.status = chtab_pkg::STS_OK;
                  e.slot = fresh[chtab_pkg::SLOT_OUT_W-1:0];
               end
            end
         end
         chtab_pkg::CMD_DELETE: begin
            find_in_chain(bucket, r.key, hit, tail);
            if (hit < NO_SLOT) begin
               if (tail < NO_SLOT) next_of[tail] = next_of[hit];
               else head_of[bucket] = next_of[hit];
               next_of[hit] = free_head;
               free_head = hit;
               if (live_count > 0) live_count--;
               e.status = chtab_pkg::STS_OK;
               e.slot = hit[chtab_pkg::SLOT_OUT_W-1:0];
            end
         end
         chtab_pkg::CMD_SEARCH: begin
            find_in_chain(bucket, r.key, hit, tail);
            if (hit < NO_SLOT) begin
               e.status = chtab_pkg::STS_OK;
               e.slot = hit[chtab_pkg::SLOT_OUT_W-1:0];
               e.name = name_at[hit];
               e.value = value_at[hit];
            end
         end
         default: begin
            // The unused command is answered as not found.
         end
      endcase
      e.count = live_count[chtab_pkg::COUNT_OUT_W-1:0];
      return e;
   endfunction

   // Print one mismatch line and count it.
   task automatic flag_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      mismatches++;
      if (mismatches <= SHOWN_MISMATCHES)
         $display("tb: %s mismatch at reply %0d: got %h, expected %h",
                  what, replies_seen, got, want);
   endtask

   task automatic queue_lookup(input chtab_pkg::cmd_type c,
                               input logic [chtab_pkg::KEY_W-1:0] k,
                               input logic [chtab_pkg::NAME_W-1:0] n,
                               input logic signed [chtab_pkg::VALUE_W-1:0] v,
                               input bit drain, input bit calm);
      table_req_type item;
      item.command = c;
      item.key = k;
      item.name = n;
      item.value = v;
      item.drain_first = drain;
      item.calm = calm;
      pending_lookups.push_back(item);
   endtask

   function automatic logic [chtab_pkg::NAME_W-1:0] random_name();
      logic [63:0] wide;
      wide = {$urandom, $urandom};
      return wide[chtab_pkg::NAME_W-1:0];
   endfunction

   // Request sender: one beat at a time, with random idle bursts.
   always @(negedge clock) begin : drive_requests
      table_req_type item;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_beat_done) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_lookups.size() == 0) begin
            req_valid <= 1'b0;
         end else if (pending_lookups[0].drain_first && predicted_replies.size() != 0) begin
            // Hold off until every outstanding response has come back.
            req_valid <= 1'b0;
         end else if (!pending_lookups[0].calm && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(0, 8);
            req_valid <= 1'b0;
         end else begin
            item = pending_lookups.pop_front();
            req_command <= item.command;
            req_key <= item.key;
            req_rec_name <= item.name;
            req_rec_value <= item.value;
            req_valid <= 1'b1;
            no_idling <= item.calm;
         end
      end
   end

   // Response sink: stalls in random bursts outside the calm stretches.
   always @(negedge clock) begin : drive_ready
      if (no_idling) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(0, 8);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Port monitor: predicts on each accepted request beat, checks each
   // accepted response beat against the oldest prediction.
   always @(posedge clock) begin : check_replies
      table_req_type taken;
      table_rsp_type want;
      req_beat_done <= !reset && req_valid && req_ready;
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;

         if (req_valid && req_ready) begin
            taken.command = req_command;
            taken.key = req_key;
            taken.name = req_rec_name;
            taken.value = req_rec_value;
            taken.drain_first = 1'b0;
            taken.calm = 1'b0;
            predicted_replies.push_back(table_step(taken));
            requests_taken++;
            if (live_count > peak_count) peak_count = live_count;
         end

         if (rsp_valid && rsp_ready) begin
            replies_seen++;
            if (predicted_replies.size() == 0) begin
               flag_mismatch("unexpected reply", 64'(rsp_status), 64'(0));
            end else begin
               want = predicted_replies.pop_front();
               status_tally[want.status]++;
               if (rsp_status !== want.status)
                  flag_mismatch("status", 64'(rsp_status), 64'(want.status));
               if (rsp_slot !== want.slot)
                  flag_mismatch("slot", 64'(rsp_slot), 64'(want.slot));
               if (rsp_found_name !== want.name)
                  flag_mismatch("found_name", 64'(rsp_found_name), 64'(want.name));
               if (rsp_found_value !== want.value)
                  flag_mismatch("found_value", 64'(rsp_found_value), 64'(want.value));
               if (rsp_entry_count !== want.count)
                  flag_mismatch("entry_count", 64'(rsp_entry_count), 64'(want.count));
            end
         end
      end
   end

   // Ends the run when neither channel has moved a beat for too long.
   initial begin : watchdog
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("tb: failure");
      $finish;
   end

   initial begin : run_test
      int          ins_pct [PHASES] = '{85, 60, 30, 70, 50, 20, 80, 55, 50};
      int          hot_count [PHASES] = '{3, 2, 3, 2, 3, 3, 1, 2, 3};
      int          hot_pct [PHASES] = '{60, 70, 50, 60, 70, 50, 100, 60, 60};
      int          hot [3];
      int          pick;
      chtab_pkg::cmd_type          c;
      logic [chtab_pkg::KEY_W-1:0] k;

      // Shadow table after reset: empty buckets, free stack threaded in order.
      for (int b = 0; b < BUCKETS; b++) head_of[b] = NO_SLOT;
      for (int s = 0; s < ENTRIES; s++) begin
         next_of[s] = (s + 1 < ENTRIES) ? 6'(s + 1) : NO_SLOT;
         key_at[s] = '0;
         name_at[s] = '0;
         value_at[s] = '0;
      end
      free_head = '0;
      live_count = '0;

      // Directed opening: empty table, extremes, one chain of three keys in
      // bucket zero exercised at its head, middle and tail.
      queue_lookup(chtab_pkg::CMD_SEARCH, 16'd5, random_name(), $urandom, 1'b0, 1'b0);
      queue_lookup(chtab_pkg::CMD_DELETE, 16'd5, random_name(), $urandom, 1'b0, 1'b0);
      queue_lookup(CMD_UNUSED, 16'd7, random_name(), $urandom, 1'b0, 1'b0);
      queue_lookup(chtab_pkg::CMD_INSERT, 16'd0, '1, 32'sh8000_0000, 1'b0, 1'b0);
      queue_lookup(chtab_pkg::CMD_INSERT, 16'hFFFF, '0, 32'sh7FFF_FFFF, 1'b0, 1'b0);
      queue_lookup(chtab_pkg::CMD_INSERT, 16'd31, random_name(), -32'sd1, 1'b0, 1'b0);
      queue_lookup(chtab_pkg::CMD_INSERT, 16'd62, random_name(), 32'sd0, 1'b0, 1'b0);
      queue_lookup(chtab_pkg::CMD_INSERT, 16'd31, random_name(), $urandom, 1'b0, 1'b0);
      queue_lookup(chtab_pkg::CMD_SEARCH, 16'd0, random_name(), $urandom, 1'b0, 1'b0);
      queue_lookup(chtab_pkg::CMD_SEARCH, 16'hFFFF, random_name(), $urandom, 1'b0, 1'b0);
      queue_lookup(chtab_pkg::CMD_SEARCH, 16'd62, random_name(), $urandom, 1'b0, 1'b0);
      queue_lookup(chtab_pkg::CMD_DELETE, 16'd31, random_name(), $urandom, 1'b0, 1'b0);
      queue_lookup(chtab_pkg::CMD_SEARCH, 16'd62, random_name(), $urandom, 1'b0, 1'b0);
      queue_lookup(chtab_pkg::CMD_SEARCH, 16'd31, random_name(), $urandom, 1'b0, 1'b0);
      queue_lookup(chtab_pkg::CMD_DELETE, 16'd0, random_name(), $urandom, 1'b0, 1'b0);
      queue_lookup(chtab_pkg::CMD_DELETE, 16'd62, random_name(), $urandom, 1'b0, 1'b0);
      queue_lookup(chtab_pkg::CMD_INSERT, 16'd93, random_name(), $urandom, 1'b0, 1'b0);
      queue_lookup(CMD_UNUSED, 16'd93, random_name(), $urandom, 1'b0, 1'b0);
      queue_lookup(chtab_pkg::CMD_SEARCH, 16'd93, random_name(), $urandom, 1'b0, 1'b0);
      queue_lookup(chtab_pkg::CMD_DELETE, 16'hFFFF, random_name(), $urandom, 1'b0, 1'b0);
      queue_lookup(chtab_pkg::CMD_DELETE, 16'd93, random_name(), $urandom, 1'b0, 1'b0);
      queue_lookup(chtab_pkg::CMD_SEARCH, 16'd0, random_name(), $urandom, 1'b0, 1'b0);

      // Random phases. Each phase draws a key pool that crowds a few hot
      // buckets, so chains grow long and the pool overflows the table.
      for (int p = 0; p < PHASES; p++) begin
         for (int h = 0; h < 3; h++) hot[h] = $urandom_range(0, BUCKETS - 1);
         for (int i = 0; i < POOL_SIZE; i++) begin
            if ($urandom_range(1, 100) <= hot_pct[p])
               key_pool[i] = 16'(hot[$urandom_range(0, hot_count[p] - 1)]
                                 + BUCKETS * $urandom_range(0, 2112));
            else
               key_pool[i] = 16'($urandom_range(0, 65535));
         end
         for (int i = 0; i < PHASE_LEN; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < ins_pct[p]) c = chtab_pkg::CMD_INSERT;
            else if (pick < ins_pct[p] + (100 - ins_pct[p]) / 2) c = chtab_pkg::CMD_DELETE;
            else if (pick < 97) c = chtab_pkg::CMD_SEARCH;
            else c = CMD_UNUSED;
            if ($urandom_range(0, 19) == 0) k = 16'($urandom_range(0, 65535));
            else k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            queue_lookup(c, k, random_name(), $urandom,
                         (i == 0) && (p % 3 == 1), (p == 3) || (p == PHASES - 1));
         end
      end

      // Reset once, released on a falling edge.
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Let the stimulus and every outstanding response drain, then settle.
      while (pending_lookups.size() != 0 || req_valid || predicted_replies.size() != 0)
         @(posedge clock);
      repeat (100) @(posedge clock);

      $display("Run covered %0d requests; replies ok %0d, not found %0d,",
               requests_taken, status_tally[chtab_pkg::STS_OK],
               status_tally[chtab_pkg::STS_NOT_FOUND]);
      $display("duplicate %0d, full %0d; longest chain walk %0d links, peak %0d of %0d.",
               status_tally[chtab_pkg::STS_DUPLICATE], status_tally[chtab_pkg::STS_FULL],
               longest_walk, peak_count, ENTRIES);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

@@ chained_hash_table_core.f @@
rtl/chtab_pkg.sv
rtl/chtab_hash.sv
rtl/chained_hash_table_core.sv
tb/chained_hash_table_core_tb.sv
